// ===== sv/hbin_pkg.sv =====
// ============================================================================
// hbin_pkg - shared types and constants for the histogram binner
// Widths of the transaction fields, register indexes and reset values, the
// control state encoding and the control bundle sent to the boundary cells.
// ============================================================================
package hbin_pkg;

   // Field widths
   localparam int SAMPLE_W   = 16;
   localparam int BIN_SEL_W  = 7;
   localparam int TOTAL_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Default number of bins
   localparam int MAX_BINS_DEF = 64;

   // Divider: one quotient bit per cycle
   localparam int DIV_STEPS = SAMPLE_W;
   localparam int STEP_W    = $clog2(DIV_STEPS + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MIN_VALUE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_VALUE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BINS_IN_USE = 2'd2;

   // Register reset values
   localparam logic [SAMPLE_W-1:0]  MIN_RST  = 16'h0000;
   localparam logic [SAMPLE_W-1:0]  MAX_RST  = 16'hFFFF;
   localparam logic [BIN_SEL_W-1:0] BINS_RST = 7'd16;

   // Control states
   typedef enum logic [2:0] {
      ST_REB_START,
      ST_REB_DIV,
      ST_REB_FILL,
      ST_IDLE,
      ST_READ,
      ST_UPDATE
   } state_type;

   // Boundary cell controls
   typedef struct packed {
      logic shift;     // take the neighbor's boundary
      logic compare;   // compare the incoming sample
   } cell_ctrl_type;

endpackage

// ===== sv/hbin_cell.sv =====
// ============================================================================
// hbin_cell - one boundary cell of the histogram binner
// Holds the upper boundary of one bin, takes its neighbor's boundary while
// the table is rebuilt, and compares each sample against its boundary. The
// cell whose compare is set while its neighbor's is clear flags the hit.
// ============================================================================
module hbin_cell
   import hbin_pkg::*;
(
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [SAMPLE_W-1:0] bnd_in,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic                ge_in,
   input  logic                active,
   input  logic                last,
   output logic [SAMPLE_W-1:0] bnd_out,
   output logic                ge_out,
   output logic                hit
);

   logic [SAMPLE_W-1:0] bnd_ff;
   logic                ge_ff;

   // Boundary shifts one cell down the row during a rebuild
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         bnd_ff <= bnd_in;
      end
   end

   // Sample at or above this boundary
   always_ff @(posedge clock) begin
      if (ctrl.compare) begin
         ge_ff <= (sample >= bnd_ff);
      end
   end

   // Top of the thermometer code among the active cells
   assign hit     = active & ge_ff & (last | ~ge_in);
   assign bnd_out = bnd_ff;
   assign ge_out  = ge_ff;

endmodule

// ===== sv/hbin_div.sv =====
// ============================================================================
// hbin_div - restoring divider for the bin width
// Divides the span by the bin count, one quotient bit per cycle, and holds
// quotient and remainder until the next start.
// ============================================================================
module hbin_div
   import hbin_pkg::*;
#(
   parameter int DEN_W = 7
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SAMPLE_W-1:0] dividend,
   input  logic [DEN_W-1:0]    divisor,
   output logic [SAMPLE_W-1:0] quotient,
   output logic [DEN_W-1:0]    remainder,
   output logic                done
);

   logic [SAMPLE_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]    den_ff;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DEN_W:0]      trial;
   logic [DEN_W:0]      diff;
   logic                fits;

   // One restoring step
   assign trial = {rem_ff, quo_ff[SAMPLE_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[SAMPLE_W-2:0], fits};
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ===== sv/histogram_binner_unit.sv =====
// ============================================================================
// histogram_binner_unit - equal-width histogram with saturating bin counts
// A row of boundary cells sorts each sample into its bin in one compare;
// a counter memory then takes a read-modify-write. Read transactions return
// one bin's count unchanged.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/stall     req_mode, req_sample, req_bin_select
//   rsp      out        rsp_valid/stall     rsp_bin_number, rsp_bin_total
//   csr      in         csr_write_enable    csr_index, csr_write_data
//
// Each transaction goes through the boundary compare at acceptance, then the
// counter memory read, then the counter write with the result registered.
// After reset and after each register write the boundaries are rebuilt: a
// start state, the divider run and the shift of the new boundaries into the
// row, during which req_stall is high. Counts are cleared at reset through
// one valid flop per bin. A stalled result holds the update stage.
// ============================================================================
module histogram_binner_unit
   import hbin_pkg::*;
#(
   parameter int MAX_BINS = MAX_BINS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic [SAMPLE_W-1:0]   req_sample,
   input  logic [BIN_SEL_W-1:0]  req_bin_select,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BIN_SEL_W-1:0]  rsp_bin_number,
   output logic [TOTAL_W-1:0]    rsp_bin_total,
   // register port
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int BIN_W = $clog2(MAX_BINS + 1);
   localparam int N_W   = (BIN_W > BIN_SEL_W) ? BIN_W : BIN_SEL_W;
   localparam int DEPTH = MAX_BINS + 1;

   // ------------------------------------------------------------------
   // Signals
   // ------------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [SAMPLE_W-1:0]  min_ff, max_ff;
   logic [BIN_SEL_W-1:0] bins_ff;
   logic [N_W-1:0]       bins_ext, n_wide;
   logic [BIN_W-1:0]     n;
   logic [SAMPLE_W-1:0]  span;

   logic                 div_start, div_done;
   logic [SAMPLE_W-1:0]  div_quo;
   logic [BIN_W-1:0]     div_rem;

   logic                 fill_step;
   logic [BIN_W-1:0]     fill_cnt_ff;
   logic [SAMPLE_W-1:0]  acc_q_ff, new_q;
   logic [BIN_W-1:0]     acc_r_ff, new_r;
   logic [BIN_W:0]       sum_r, sub_r;
   logic                 wrap;
   logic [SAMPLE_W-1:0]  new_bnd;

   cell_ctrl_type        cell_ctrl;
   logic [SAMPLE_W-1:0]  bnd_vec [MAX_BINS];
   logic [MAX_BINS-1:0]  ge_vec, hit_vec, active_vec, last_vec;
   logic [BIN_W-1:0]     enc_bin, add_bin, cur_bin;

   logic                 accept, out_free, load_rsp, mem_we;
   logic                 mode_ff, min_ge_ff;
   logic [N_W-1:0]       sel_ext;
   logic [BIN_W-1:0]     sel_bin_in, sel_bin_ff, bin_ff;
   logic [N_W-1:0]       bin_wide;

   logic [TOTAL_W-1:0]   cnt_mem [DEPTH];
   logic [DEPTH-1:0]     cnt_vld_ff;
   logic [TOTAL_W-1:0]   rd_data_ff, cur_total, new_total;
   logic                 rd_vld_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BIN_SEL_W-1:0] rsp_bin_number_ff;
   logic [TOTAL_W-1:0]   rsp_bin_total_ff;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= MIN_RST;
         max_ff  <= MAX_RST;
         bins_ff <= BINS_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_MIN_VALUE:   min_ff  <= csr_write_data;
            REG_MAX_VALUE:   max_ff  <= csr_write_data;
            REG_BINS_IN_USE: bins_ff <= csr_write_data[BIN_SEL_W-1:0];
            default:         ;
         endcase
      end
   end

   // Effective bin count, clamped to 1..MAX_BINS
   assign bins_ext = N_W'(bins_ff);
   always_comb begin
      if (bins_ff == '0) begin
         n_wide = N_W'(1);
      end else if (bins_ext > N_W'(MAX_BINS)) begin
         n_wide = N_W'(MAX_BINS);
      end else begin
         n_wide = bins_ext;
      end
   end
   assign n    = n_wide[BIN_W-1:0];
   assign span = (max_ff >= min_ff) ? (max_ff - min_ff) : '0;

   // ------------------------------------------------------------------
   // Bin width: span / n
   // ------------------------------------------------------------------
   hbin_div #(
      .DEN_W (BIN_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (span),
      .divisor   (n),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   // ------------------------------------------------------------------
   // Boundary generation: add quotient and remainder once per bin
   // ------------------------------------------------------------------
   assign sum_r   = {1'b0, acc_r_ff} + {1'b0, div_rem};
   assign sub_r   = sum_r - {1'b0, n};
   assign wrap    = (sum_r >= {1'b0, n});
   assign new_r   = wrap ? sub_r[BIN_W-1:0] : sum_r[BIN_W-1:0];
   assign new_q   = acc_q_ff + div_quo + SAMPLE_W'(wrap);
   assign new_bnd = (fill_cnt_ff < n) ? (min_ff + new_q) : min_ff;

   always_ff @(posedge clock) begin
      if (div_start) begin
         fill_cnt_ff <= '0;
         acc_q_ff    <= '0;
         acc_r_ff    <= '0;
      end else if (fill_step) begin
         fill_cnt_ff <= fill_cnt_ff + BIN_W'(1);
         acc_q_ff    <= new_q;
         acc_r_ff    <= new_r;
      end
   end

   // ------------------------------------------------------------------
   // Row of boundary cells; new boundaries enter at the top cell
   // ------------------------------------------------------------------
   for (genvar b = 0; b < MAX_BINS; b++) begin : g_cell
      logic [SAMPLE_W-1:0] nb_bnd;
      logic                nb_ge;

      if (b == MAX_BINS - 1) begin : g_top
         assign nb_bnd = new_bnd;
         assign nb_ge  = 1'b0;
      end else begin : g_mid
         assign nb_bnd = bnd_vec[b+1];
         assign nb_ge  = ge_vec[b+1];
      end

      assign active_vec[b] = (BIN_W'(b) < n);
      assign last_vec[b]   = (BIN_W'(b) == (n - BIN_W'(1)));

      hbin_cell u_cell (
         .clock   (clock),
         .ctrl    (cell_ctrl),
         .bnd_in  (nb_bnd),
         .sample  (req_sample),
         .ge_in   (nb_ge),
         .active  (active_vec[b]),
         .last    (last_vec[b]),
         .bnd_out (bnd_vec[b]),
         .ge_out  (ge_vec[b]),
         .hit     (hit_vec[b])
      );
   end

   // Hit cell b means bin b+1; no hit means bin zero or out of range
   always_comb begin
      enc_bin = '0;
      for (int b = 0; b < MAX_BINS; b++) begin
         if (hit_vec[b]) begin
            enc_bin = enc_bin | BIN_W'(b + 1);
         end
      end
   end
   assign add_bin = (|hit_vec) ? enc_bin : (min_ge_ff ? '0 : n);

   // ------------------------------------------------------------------
   // Transaction capture
   // ------------------------------------------------------------------
   assign sel_ext    = N_W'(req_bin_select);
   assign sel_bin_in = (sel_ext >= n_wide) ? n : sel_ext[BIN_W-1:0];

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= req_mode;
         min_ge_ff  <= (req_sample >= min_ff);
         sel_bin_ff <= sel_bin_in;
      end
   end

   assign cur_bin = mode_ff ? sel_bin_ff : add_bin;

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         bin_ff <= cur_bin;
      end
   end

   // ------------------------------------------------------------------
   // Count memory, valid flop per bin reads as zero until written
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cnt_mem[bin_ff] <= new_total;
      end
      rd_data_ff <= cnt_mem[cur_bin];
      rd_vld_ff  <= cnt_vld_ff[cur_bin];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
      end else if (mem_we) begin
         cnt_vld_ff[bin_ff] <= 1'b1;
      end
   end

   // Saturating increment
   assign cur_total = rd_vld_ff ? rd_data_ff : '0;
   assign new_total = (!mode_ff && (cur_total != '1)) ? (cur_total + TOTAL_W'(1))
                                                       : cur_total;

   // ------------------------------------------------------------------
   // Control: next state
   // ------------------------------------------------------------------
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign accept   = req_valid & ~req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_REB_START: state_in = ST_REB_DIV;
         ST_REB_DIV: begin
            if (div_done) begin
               state_in = ST_REB_FILL;
            end
         end
         ST_REB_FILL: begin
            if (fill_cnt_ff == BIN_W'(MAX_BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (out_free) begin
               state_in = req_valid ? ST_READ : ST_IDLE;
            end
         end
         default:   state_in = ST_REB_START;
      endcase
      if (csr_write_enable) begin
         state_in = ST_REB_START;
      end
   end

   // Control: outputs
   always_comb begin
      div_start         = 1'b0;
      fill_step         = 1'b0;
      req_stall         = 1'b1;
      load_rsp          = 1'b0;
      mem_we            = 1'b0;
      case (state_ff)
         ST_REB_START: div_start = 1'b1;
         ST_REB_FILL:  fill_step = 1'b1;
         ST_IDLE:      req_stall = reset;
         ST_UPDATE: begin
            req_stall = reset | ~out_free;
            load_rsp  = out_free;
            mem_we    = out_free & ~mode_ff;
         end
         default:      ;
      endcase
      cell_ctrl.shift   = fill_step;
      cell_ctrl.compare = req_valid & ~req_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_REB_START;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   assign bin_wide     = N_W'(bin_ff);
   assign rsp_valid_in = load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_bin_number_ff <= bin_wide[BIN_SEL_W-1:0];
         rsp_bin_total_ff  <= new_total;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bin_number = rsp_bin_number_ff;
   assign rsp_bin_total  = rsp_bin_total_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
`ifndef SYNTHESIS
   // boundaries are monotone, so at most one cell sees the top of the code
   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && !mode_ff) |-> $onehot0(hit_vec))
      else $error("more than one boundary cell hit");

   // a new result only comes out of the update stage
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("result raised outside the update stage");

   // memory read is followed by its update unless a register write intervenes
   a_read_then_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && !csr_write_enable) |=> (state_ff == ST_UPDATE))
      else $error("read stage not followed by update");

   // no transaction taken while the boundary row is rebuilt
   a_no_accept_rebuild: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REB_START || state_ff == ST_REB_DIV ||
       state_ff == ST_REB_FILL) |-> req_stall)
      else $error("request accepted during rebuild");
`endif

endmodule

// ===== bench/tb_top.sv =====
// ============================================================================
// tb_top - self-checking bench for histogram_binner_unit
// A directed script of samples, reads and register writes comes first, some
// rows with hand-typed results. Random phases follow, each under a fresh
// range and bin count, with bursty request traffic and a result side that
// stalls in spells. Every accepted result is checked against its typed-in
// result or a cycle-independent model of the bin edges and saturating counters.
// ============================================================================
module tb_top;
   import hbin_pkg::*;

   localparam int NUM_BINS        = MAX_BINS_DEF;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int ERROR_PRINTS    = 100;

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_READ = 1'b1;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_HOLD} rx_style_type;

   typedef struct {
      row_kind_type          kind;
      logic                  mode;
      logic [SAMPLE_W-1:0]   data;   // sample, or register data
      logic [BIN_SEL_W-1:0]  sel;
      logic [CSR_IDX_W-1:0]  idx;
      bit                    pinned; // result typed in below
      logic [BIN_SEL_W-1:0]  pin_bin;
      logic [TOTAL_W-1:0]    pin_total;
   } script_row_type;

   typedef struct packed {
      logic [BIN_SEL_W-1:0] bin;
      logic [TOTAL_W-1:0]   total;
   } bin_result_type;

   // DUT ports
   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_mode;
   logic [SAMPLE_W-1:0]   req_sample;
   logic [BIN_SEL_W-1:0]  req_bin_select;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [BIN_SEL_W-1:0]  rsp_bin_number;
   logic [TOTAL_W-1:0]    rsp_bin_total;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   // typed-in result travelling alongside the request
   logic                  pin_valid;
   logic [BIN_SEL_W-1:0]  pin_bin;
   logic [TOTAL_W-1:0]    pin_total;

   // histogram model state
   logic [SAMPLE_W-1:0]   cfg_min;
   logic [SAMPLE_W-1:0]   cfg_max;
   logic [BIN_SEL_W-1:0]  cfg_bins;
   logic [SAMPLE_W-1:0]   bin_bound [NUM_BINS];
   logic [TOTAL_W-1:0]    hist_count [NUM_BINS+1];

   bin_result_type expected_bins[$];
   script_row_type script[$];

   int errors;
   int cycle_count;
   int adds, reads, out_of_range, reg_writes, settings;
   int burst_left;
   int gap_max;

   histogram_binner_unit #(.MAX_BINS(NUM_BINS)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_sample       (req_sample),
      .req_bin_select   (req_bin_select),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bin_number   (rsp_bin_number),
      .rsp_bin_total    (rsp_bin_total),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // --------------------------------------------------------------------------
   // Histogram model
   // --------------------------------------------------------------------------

   // bin count register, clamped to 1..NUM_BINS
   function automatic int unsigned bins_used();
      int unsigned n;
      n = cfg_bins;
      if (n == 0) n = 1;
      if (n > NUM_BINS) n = NUM_BINS;
      return n;
   endfunction

   // upper edges; a reversed range collapses every edge onto the minimum
   function automatic void rebuild_bounds();
      int unsigned n, span, e;
      n = bins_used();
      span = (cfg_max >= cfg_min) ? cfg_max - cfg_min : 0;
      for (int b = 0; b < NUM_BINS; b++) begin
         e = cfg_min;
         if (b < n) e = cfg_min + (span * (b + 1)) / n;
         bin_bound[b] = e[SAMPLE_W-1:0];
      end
   endfunction

   function automatic void reset_model();
      cfg_min  = MIN_RST;
      cfg_max  = MAX_RST;
      cfg_bins = BINS_RST;
      for (int b = 0; b <= NUM_BINS; b++) hist_count[b] = '0;
      rebuild_bounds();
   endfunction

   // unknown indexes leave everything alone
   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_MIN_VALUE:   cfg_min  = data;
         REG_MAX_VALUE:   cfg_max  = data;
         REG_BINS_IN_USE: cfg_bins = data[BIN_SEL_W-1:0];
         default:         return;
      endcase
      rebuild_bounds();
   endfunction

   // highest bin whose lower edge is at or below the sample; n is out of range
   function automatic int unsigned bin_of_sample(logic [SAMPLE_W-1:0] smp, int unsigned n);
      if (bin_bound[n-1] <= smp) return n;
      for (int i = n - 1; i > 0; i--)
         if (bin_bound[i-1] <= smp) return i;
      return (cfg_min <= smp) ? 0 : n;
   endfunction

   // one transaction: update or read, counts saturate
   function automatic bin_result_type bin_predict(logic mode, logic [SAMPLE_W-1:0] smp,
                                                  logic [BIN_SEL_W-1:0] sel);
      int unsigned n, b;
      bin_result_type r;
      n = bins_used();
      if (mode == MODE_ADD) begin
         b = bin_of_sample(smp, n);
         if (hist_count[b] != '1) hist_count[b] = hist_count[b] + 1;
      end else begin
         b = sel;
         if (b >= n) b = n;
      end
      r.bin   = b[BIN_SEL_W-1:0];
      r.total = hist_count[b];
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // Checker: results against the oldest expectation, then new requests
   // --------------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [TOTAL_W-1:0] want,
                                  logic [TOTAL_W-1:0] got);
      if (errors < ERROR_PRINTS)
         $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
      errors++;
   endtask

   always @(posedge clock) begin
      bin_result_type want;
      int unsigned n;
      if (reset) begin
         reset_model();
         expected_bins.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bins.size() == 0) begin
               report_mismatch("unexpected result, bin_number", '0, rsp_bin_number);
            end else begin
               want = expected_bins.pop_front();
               if (rsp_bin_number !== want.bin)
                  report_mismatch("bin_number", want.bin, rsp_bin_number);
               if (rsp_bin_total !== want.total)
                  report_mismatch("bin_total", want.total, rsp_bin_total);
            end
         end
         if (req_valid && !req_stall) begin
            n = bins_used();
            want = bin_predict(req_mode, req_sample, req_bin_select);
            if (pin_valid) begin
               want.bin   = pin_bin;
               want.total = pin_total;
            end
            if (req_mode == MODE_ADD) begin
               adds++;
               if (want.bin == n) out_of_range++;
            end else begin
               reads++;
            end
            expected_bins.push_back(want);
         end
         if (csr_write_enable) apply_reg(csr_index, csr_write_data);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Result side: stall spells, every sixth one a long hold-off
   // --------------------------------------------------------------------------
   initial begin : rsp_side
      int seg, span_len;
      rx_style_type style;
      rsp_stall = 1'b0;
      seg = 0;
      forever begin
         style = (seg % 6 == 5) ? RX_HOLD : rx_style_type'($urandom_range(0, 2));
         span_len = (style == RX_HOLD) ? $urandom_range(40, 120) : $urandom_range(20, 200);
         repeat (span_len) begin
            @(posedge clock);
            case (style)
               RX_FREE:  rsp_stall <= 1'b0;
               RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               RX_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:  rsp_stall <= 1'b1;
            endcase
         end
         seg++;
      end
   end

   // --------------------------------------------------------------------------
   // Request side helpers
   // --------------------------------------------------------------------------

   // present one transaction and hold it until taken
   task automatic offer_item(logic mode, logic [SAMPLE_W-1:0] smp, logic [BIN_SEL_W-1:0] sel,
                             bit pinned, logic [BIN_SEL_W-1:0] pbin, logic [TOTAL_W-1:0] ptotal);
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_sample     <= smp;
      req_bin_select <= sel;
      pin_valid      <= pinned;
      pin_bin        <= pbin;
      pin_total      <= ptotal;
      do @(posedge clock); while (req_stall);
   endtask

   // end of a burst: maybe leave the request line idle for a random gap
   task automatic maybe_gap();
      int gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // drain all results, settle, and wait out any edge rebuild
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_bins.size() != 0);
      repeat (4) @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      do @(posedge clock); while (req_stall);
      reg_writes++;
   endtask

   function automatic void add_item(logic mode, logic [SAMPLE_W-1:0] smp,
                                    logic [BIN_SEL_W-1:0] sel, bit pinned = 1'b0,
                                    logic [BIN_SEL_W-1:0] pbin = '0,
                                    logic [TOTAL_W-1:0] ptotal = '0);
      script_row_type row;
      row.kind = ROW_ITEM;
      row.mode = mode;
      row.data = smp;
      row.sel = sel;
      row.idx = '0;
      row.pinned = pinned;
      row.pin_bin = pbin;
      row.pin_total = ptotal;
      script.push_back(row);
   endfunction

   function automatic void add_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      script_row_type row;
      row.kind = ROW_CSR;
      row.mode = MODE_ADD;
      row.data = data;
      row.sel = '0;
      row.idx = idx;
      row.pinned = 1'b0;
      row.pin_bin = '0;
      row.pin_total = '0;
      script.push_back(row);
   endfunction

   // samples: mostly inside the range, many right at an edge
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int unsigned n, r, b, s;
      n = bins_used();
      r = $urandom_range(0, 99);
      if (r < 10) begin
         s = $urandom_range(0, 65535);
      end else if (r < 20) begin
         case ($urandom_range(0, 5))
            0:       s = 0;
            1:       s = 65535;
            2:       s = cfg_min;
            3:       s = cfg_max;
            4:       s = cfg_min - 1;
            default: s = cfg_max + 1;
         endcase
      end else if (r < 45) begin
         b = $urandom_range(0, n - 1);
         s = bin_bound[b] + $urandom_range(0, 2) - 1;
      end else if (cfg_min <= cfg_max) begin
         s = $urandom_range(cfg_min, cfg_max);
      end else begin
         s = $urandom_range(0, 65535);
      end
      return s[SAMPLE_W-1:0];
   endfunction

   function automatic logic [BIN_SEL_W-1:0] pick_select();
      int unsigned n, r, s;
      n = bins_used();
      r = $urandom_range(0, 9);
      if (r < 7) s = $urandom_range(0, n);
      else if (r < 9) s = $urandom_range(0, 127);
      else
         case ($urandom_range(0, 2))
            0:       s = n;
            1:       s = NUM_BINS;
            default: s = 127;
         endcase
      return s[BIN_SEL_W-1:0];
   endfunction

   // new range and bin count, extremes and odd settings included
   task automatic configure_random();
      logic [SAMPLE_W-1:0] lo, hi;
      logic [BIN_SEL_W-1:0] nb;
      logic [CSR_DATA_W-1:0] bins_word;
      lo = $urandom_range(0, 65535);
      hi = $urandom_range(lo, 65535);
      nb = $urandom_range(1, NUM_BINS);
      case ($urandom_range(0, 9))
         0: begin lo = 0; hi = 65535; nb = 0; end
         1: begin hi = $urandom_range(0, 65535); nb = $urandom_range(NUM_BINS + 1, 127); end
         2: begin
               hi = $urandom_range(0, 65534);
               lo = $urandom_range(hi + 1, 65535);
            end
         3: hi = lo;
         4: begin lo = 0; hi = 65535; nb = NUM_BINS; end
         5: begin lo = 0; hi = 65535; nb = 1; end
         default: ;
      endcase
      // upper bits of the bin count word are don't-care
      bins_word = {($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'd0, nb};
      write_reg(REG_MIN_VALUE, lo);
      write_reg(REG_MAX_VALUE, hi);
      write_reg(REG_BINS_IN_USE, bins_word);
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 16'($urandom));
      settings++;
   endtask

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin
      logic m;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = MODE_ADD;
      req_sample       = '0;
      req_bin_select   = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      pin_valid        = 1'b0;
      pin_bin          = '0;
      pin_total        = '0;
      errors           = 0;
      adds             = 0;
      reads            = 0;
      out_of_range     = 0;
      reg_writes       = 0;
      settings         = 1;
      burst_left       = 0;
      gap_max          = 4;
      reset_model();

      // Directed script. Reset setting: 16 bins over the full range,
      // first edge at 4095, last edge at 65535 so 65535 is out of range.
      add_item(MODE_ADD,  16'd0,     '0, 1'b1, 7'd0,  32'd1);
      add_item(MODE_ADD,  16'd65535, '0, 1'b1, 7'd16, 32'd1);
      add_item(MODE_ADD,  16'd4095,  '0, 1'b1, 7'd1,  32'd1);
      add_item(MODE_ADD,  16'd4094,  '0, 1'b1, 7'd0,  32'd2);
      add_item(MODE_ADD,  16'd65534, '0);
      add_item(MODE_READ, '0, 7'd0,   1'b1, 7'd0,  32'd2);
      add_item(MODE_READ, '0, 7'd127, 1'b1, 7'd16, 32'd1);
      add_item(MODE_READ, '0, 7'd64);
      add_item(MODE_READ, '0, 7'd16,  1'b1, 7'd16, 32'd1);
      // zero bin count acts as one bin; counts stay put by index
      add_csr(REG_BINS_IN_USE, 16'd0);
      add_item(MODE_ADD,  16'd65534, '0);
      add_item(MODE_ADD,  16'd65535, '0);
      add_item(MODE_READ, '0, 7'd5);
      // oversized bin count, maximum below minimum: all out of range
      add_csr(REG_BINS_IN_USE, 16'd127);
      add_csr(REG_MIN_VALUE, 16'd100);
      add_csr(REG_MAX_VALUE, 16'd99);
      add_item(MODE_ADD,  16'd100,   '0);
      add_item(MODE_ADD,  16'd0,     '0);
      add_item(MODE_ADD,  16'd65535, '0);
      // write to an unused index is dropped
      add_csr(REG_UNUSED, 16'hFFFF);
      add_item(MODE_READ, '0, 7'd64);
      // full range, all bins
      add_csr(REG_MIN_VALUE, 16'd0);
      add_csr(REG_MAX_VALUE, 16'd65535);
      add_csr(REG_BINS_IN_USE, 16'd64);
      add_item(MODE_ADD,  16'd1022,  '0);
      add_item(MODE_ADD,  16'd1023,  '0);
      add_item(MODE_ADD,  16'd65535, '0);
      add_item(MODE_READ, '0, 7'd63);
      // empty range at the top of the scale
      add_csr(REG_MIN_VALUE, 16'd65535);
      add_csr(REG_BINS_IN_USE, 16'd1);
      add_item(MODE_ADD,  16'd65535, '0);
      add_item(MODE_ADD,  16'd65534, '0);
      add_item(MODE_READ, '0, 7'd0);
      // empty range at zero
      add_csr(REG_MIN_VALUE, 16'd0);
      add_csr(REG_MAX_VALUE, 16'd0);
      add_item(MODE_ADD,  16'd0,     '0);
      add_item(MODE_ADD,  16'd65535, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < script.size(); i++) begin
         if (script[i].kind == ROW_CSR) begin
            write_reg(script[i].idx, script[i].data);
         end else begin
            offer_item(script[i].mode, script[i].data, script[i].sel, script[i].pinned,
                       script[i].pin_bin, script[i].pin_total);
            if (i + 1 < script.size() && script[i+1].kind == ROW_ITEM) maybe_gap();
         end
      end

      // Random phases, each under a fresh setting
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         configure_random();
         gap_max = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 8);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            m = ($urandom_range(0, 3) == 0) ? MODE_READ : MODE_ADD;
            offer_item(m, pick_sample(), pick_select(), 1'b0, '0, '0);
            if (k + 1 < ITEMS_PER_PHASE) maybe_gap();
         end
      end

      // Drain and let the pipeline settle
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_bins.size() != 0);
      repeat (10) @(posedge clock);

      $display("tb: %0d sample updates (%0d out of range), %0d count reads", adds,
               out_of_range, reads);
      $display("tb: %0d register settings, %0d register writes, %0d mismatches", settings,
               reg_writes, errors);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== files.f =====
sv/hbin_pkg.sv
sv/hbin_cell.sv
sv/hbin_div.sv
sv/histogram_binner_unit.sv
bench/tb_top.sv
